// ===== design/lr_pkg.sv =====
// Shared types and constants of the line rasterizer.
// Used by the interfaces, the pixel stepper and the top level; depends on nothing.
package lr_pkg;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  // The error term needs this many bits beyond the coordinate width, sign included.
  localparam int unsigned ERR_EXTRA_BITS = 3;

endpackage

// ===== design/lr_if.sv =====
// Request and result channels of the line rasterizer, valid/ready handshake.
// Depends on lr_pkg for the mode type.
interface lr_in_if #(
  parameter int unsigned COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  lr_pkg::mode_e         mode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic                  restore;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, restore, input ready);
  modport sink   (input valid, mode, start_x, start_y, end_x, end_y, restore, output ready);
endinterface

interface lr_out_if #(
  parameter int unsigned COORD_BITS = 11
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  restore_pixel;
  logic                  last;

  modport source (output valid, pixel_x, pixel_y, restore_pixel, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, restore_pixel, last, output ready);
endinterface

// ===== design/lr_stepper.sv =====
// Line state registers and the combinational Bresenham step.
// Depends on lr_pkg; its result feeds the output buffer in the top level.
module lr_stepper #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  lr_pkg::mode_e         mode_i,
  input  logic [COORD_BITS-1:0] start_x_i,
  input  logic [COORD_BITS-1:0] start_y_i,
  input  logic [COORD_BITS-1:0] end_x_i,
  input  logic [COORD_BITS-1:0] end_y_i,
  input  logic                  restore_i,
  output logic                  res_valid_o,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  restore_pixel_o,
  output logic                  last_o
);
  import lr_pkg::*;

  localparam int unsigned EW = COORD_BITS + ERR_EXTRA_BITS;

  logic                  active_q, active_d;
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] target_x_q, target_x_d, target_y_q, target_y_d;
  logic [COORD_BITS-1:0] span_x_q, span_x_d, span_y_q, span_y_d;
  logic                  sign_x_q, sign_x_d, sign_y_q, sign_y_d;
  logic signed [EW-1:0]  err_q, err_d;
  logic                  restore_q, restore_d;
  logic                  is_last;

  always_comb begin
    logic signed [EW-1:0]  sx;
    logic signed [EW-1:0]  sx2;
    logic signed [EW-1:0]  sy2;
    logic signed [EW-1:0]  e1;
    logic [COORD_BITS-1:0] step_x;
    logic [COORD_BITS-1:0] step_y;

    active_d   = active_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    span_x_d   = span_x_q;
    span_y_d   = span_y_q;
    sign_x_d   = sign_x_q;
    sign_y_d   = sign_y_q;
    err_d      = err_q;
    restore_d  = restore_q;

    sx      = $signed({{ERR_EXTRA_BITS{1'b0}}, span_x_q});
    sx2     = $signed({{(ERR_EXTRA_BITS-1){1'b0}}, span_x_q, 1'b0});
    sy2     = $signed({{(ERR_EXTRA_BITS-1){1'b0}}, span_y_q, 1'b0});
    e1      = err_q - sx2;
    step_x  = sign_x_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
    step_y  = sign_y_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;

    is_last = (cur_x_q == target_x_q) && (cur_y_q == target_y_q);

    res_valid_o     = take_i && (mode_i == MODE_ADVANCE) && active_q;
    pixel_x_o       = cur_x_q;
    pixel_y_o       = cur_y_q;
    restore_pixel_o = restore_q;
    last_o          = is_last;

    if (take_i && (mode_i == MODE_START)) begin
      cur_x_d    = start_x_i;
      cur_y_d    = start_y_i;
      target_x_d = end_x_i;
      target_y_d = end_y_i;
      restore_d  = restore_i;
      sign_x_d   = end_x_i < start_x_i;
      sign_y_d   = end_y_i < start_y_i;
      span_x_d   = sign_x_d ? start_x_i - end_x_i : end_x_i - start_x_i;
      span_y_d   = sign_y_d ? start_y_i - end_y_i : end_y_i - start_y_i;
      err_d      = $signed({{(ERR_EXTRA_BITS-1){1'b0}}, span_y_d, 1'b0});
      active_d   = 1'b1;
    end else if (res_valid_o) begin
      if (is_last) begin
        active_d = 1'b0;
      end else if ((span_x_q == '0) || (cur_x_q == target_x_q)) begin
        cur_y_d = step_y;
      end else if ((err_q >= sx) && (cur_y_q != target_y_q)) begin
        if ((e1 >= sx) && (step_y != target_y_q)) begin
          cur_y_d = step_y;
          err_d   = e1;
        end else begin
          cur_x_d = step_x;
          cur_y_d = step_y;
          err_d   = e1 + sy2;
        end
      end else begin
        cur_x_d = step_x;
        err_d   = err_q + sy2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      target_x_q <= '0;
      target_y_q <= '0;
      span_x_q   <= '0;
      span_y_q   <= '0;
      sign_x_q   <= 1'b0;
      sign_y_q   <= 1'b0;
      err_q      <= '0;
      restore_q  <= 1'b0;
    end else begin
      active_q   <= active_d;
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      target_x_q <= target_x_d;
      target_y_q <= target_y_d;
      span_x_q   <= span_x_d;
      span_y_q   <= span_y_d;
      sign_x_q   <= sign_x_d;
      sign_y_q   <= sign_y_d;
      err_q      <= err_d;
      restore_q  <= restore_d;
    end
  end

  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && last_o |=> !active_q)
    else $error("line still active after its last pixel");

  a_vertical_keeps_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_x_q == '0 |-> cur_x_q == target_x_q)
    else $error("vertical line moved off its column");

  a_err_lower_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> err_q >= -$signed({{ERR_EXTRA_BITS{1'b0}}, span_x_q}))
    else $error("error term fell below its lower bound");

endmodule

// ===== design/lr_out_buf.sv =====
// Two-entry result buffer: an output register with a skid register behind it.
// Self-contained; the top level packs the pixel fields into its data word.
module lr_out_buf #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);
  logic             head_v_q, head_v_d, skid_v_q, skid_v_d;
  logic [WIDTH-1:0] head_q, head_d, skid_q, skid_d;
  logic             pop;

  assign pop     = head_v_q && ready_i;
  assign space_o = !skid_v_q;
  assign valid_o = head_v_q;
  assign data_o  = head_q;

  always_comb begin
    head_v_d = head_v_q;
    head_d   = head_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (pop || !head_v_q) begin
      if (skid_v_q) begin
        head_v_d = 1'b1;
        head_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = data_i;
      end else begin
        head_v_d = push_i;
        head_d   = data_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> head_v_q)
    else $error("skid entry held with an empty output register");

  a_push_when_full_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_v_q || pop)
    else $error("result pushed into a full buffer");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && head_v_q && !pop |=> skid_v_q && head_v_q)
    else $error("result not kept while the output stalls");

endmodule

// ===== design/line_rasterizer.sv =====
// Line rasterizer: a start request loads a line, each advance request while a line is active yields one pixel.
// A pixel reaches out_o through the output register of the buffer, or through its skid register first on a stall.
// Throughput: one request per cycle while the output buffer has space, set by the step logic of lr_stepper.
// A two-entry output buffer keeps in_i ready during an output stall until its skid register holds a result.
// Reset clears the line state (no line active) and empties the output buffer.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = 11
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lr_in_if.sink   in_i,
  lr_out_if.source out_o
);
  import lr_pkg::*;

  localparam int unsigned RES_W = 2 * COORD_BITS + 2;

  logic                  take;
  logic                  space;
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x;
  logic [COORD_BITS-1:0] res_y;
  logic                  res_restore;
  logic                  res_last;
  logic [RES_W-1:0]      buf_out;

  assign in_i.ready = space;
  assign take       = in_i.valid && space;

  lr_stepper #(
    .COORD_BITS(COORD_BITS)
  ) u_stepper (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .mode_i         (in_i.mode),
    .start_x_i      (in_i.start_x),
    .start_y_i      (in_i.start_y),
    .end_x_i        (in_i.end_x),
    .end_y_i        (in_i.end_y),
    .restore_i      (in_i.restore),
    .res_valid_o    (res_valid),
    .pixel_x_o      (res_x),
    .pixel_y_o      (res_y),
    .restore_pixel_o(res_restore),
    .last_o         (res_last)
  );

  lr_out_buf #(
    .WIDTH(RES_W)
  ) u_out_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_valid),
    .data_i ({res_x, res_y, res_restore, res_last}),
    .space_o(space),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .data_o (buf_out)
  );

  assign out_o.pixel_x       = buf_out[RES_W-1 -: COORD_BITS];
  assign out_o.pixel_y       = buf_out[2 +: COORD_BITS];
  assign out_o.restore_pixel = buf_out[1];
  assign out_o.last          = buf_out[0];

endmodule

// ===== test/tb_line_rasterizer.sv =====
// Testbench of line_rasterizer: start and advance requests in, pixels out, predicted per request.
// Depends on lr_pkg, the lr_in_if and lr_out_if interfaces and the line_rasterizer top level.
// Runs directed corner lines, a long output hold-off and random lines under four idle/stall settings.
`timescale 1ns / 1ps

module tb_line_rasterizer;
  import lr_pkg::*;

  localparam int unsigned CB = 11;
  localparam int COORD_MAX = (1 << CB) - 1;

  typedef logic [CB-1:0] coord_t;

  typedef struct {
    mode_e  mode;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   restore;
  } line_req_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   restore_pixel;
    logic   last;
  } pixel_t;

  logic clk;
  logic rst_n;

  lr_in_if  #(.COORD_BITS(CB)) req_if ();
  lr_out_if #(.COORD_BITS(CB)) pix_if ();

  line_rasterizer #(.COORD_BITS(CB)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (req_if),
    .out_o  (pix_if)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Predicted line walker state.
  logic   line_active;
  coord_t walk_x, walk_y, goal_x, goal_y;
  int     dist_x, dist_y;
  logic   down_x, down_y;
  int     slope_err;
  logic   restore_latched;

  pixel_t pixel_expected[$];

  int send_idle_pct;
  int recv_stall_pct;
  logic hold_off;

  int requests_sent;
  int lines_started;
  int pixels_checked;
  int pixel_errors;

  function automatic coord_t step_coord(coord_t v, logic negative);
    return negative ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
  endfunction

  task automatic walk_one_pixel();
    int     e;
    coord_t ny;
    if (dist_x == 0 || walk_x == goal_x) begin
      walk_y = step_coord(walk_y, down_y);
      return;
    end
    e  = slope_err;
    ny = walk_y;
    if (e >= dist_x && walk_y != goal_y) begin
      e  = e - 2 * dist_x;
      ny = step_coord(walk_y, down_y);
      if (e >= dist_x && ny != goal_y) begin
        walk_y    = ny;
        slope_err = e;
        return;
      end
    end
    walk_x    = step_coord(walk_x, down_x);
    walk_y    = ny;
    slope_err = e + 2 * dist_y;
  endtask

  task automatic rasterize_request(line_req_t r);
    pixel_t p;
    if (r.mode == MODE_START) begin
      walk_x          = r.sx;
      walk_y          = r.sy;
      goal_x          = r.ex;
      goal_y          = r.ey;
      restore_latched = r.restore;
      down_x          = goal_x < walk_x;
      down_y          = goal_y < walk_y;
      dist_x          = down_x ? int'(walk_x) - int'(goal_x) : int'(goal_x) - int'(walk_x);
      dist_y          = down_y ? int'(walk_y) - int'(goal_y) : int'(goal_y) - int'(walk_y);
      slope_err       = 2 * dist_y;
      line_active     = 1'b1;
      lines_started++;
      return;
    end
    if (!line_active) return;
    p.px            = walk_x;
    p.py            = walk_y;
    p.restore_pixel = restore_latched;
    p.last          = (walk_x == goal_x) && (walk_y == goal_y);
    pixel_expected.push_back(p);
    if (p.last) line_active = 1'b0;
    else walk_one_pixel();
  endtask

  task automatic send_request(mode_e mode, int sx, int sy, int ex, int ey, logic restore);
    line_req_t r;
    r.mode    = mode;
    r.sx      = coord_t'(sx);
    r.sy      = coord_t'(sy);
    r.ex      = coord_t'(ex);
    r.ey      = coord_t'(ey);
    r.restore = restore;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.mode    <= r.mode;
    req_if.start_x <= r.sx;
    req_if.start_y <= r.sy;
    req_if.end_x   <= r.ex;
    req_if.end_y   <= r.ey;
    req_if.restore <= r.restore;
    do @(posedge clk); while (!req_if.ready);
    requests_sent++;
    rasterize_request(r);
  endtask

  task automatic advance_request();
    send_request(MODE_ADVANCE, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                 $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                 1'($urandom_range(1)));
  endtask

  // Receiver: random stalls, an optional long hold-off, and the pixel check.
  always @(posedge clk) begin
    pixel_t exp_p;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      pixels_checked++;
      if (pixel_expected.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= 10)
          $display("Unexpected pixel x=%0d y=%0d restore=%0b last=%0b", pix_if.pixel_x,
                   pix_if.pixel_y, pix_if.restore_pixel, pix_if.last);
      end else begin
        exp_p = pixel_expected.pop_front();
        if (pix_if.pixel_x !== exp_p.px || pix_if.pixel_y !== exp_p.py ||
            pix_if.restore_pixel !== exp_p.restore_pixel || pix_if.last !== exp_p.last) begin
          pixel_errors++;
          if (pixel_errors <= 10)
            $display("Pixel mismatch: expected x=%0d y=%0d restore=%0b last=%0b,",
                     exp_p.px, exp_p.py, exp_p.restore_pixel, exp_p.last,
                     " got x=%0d y=%0d restore=%0b last=%0b", pix_if.pixel_x,
                     pix_if.pixel_y, pix_if.restore_pixel, pix_if.last);
        end
      end
    end
    pix_if.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic test_corner_lines();
    advance_request();
    send_request(MODE_START, COORD_MAX, 0, COORD_MAX, 0, 1'b1);
    repeat (2) advance_request();
    send_request(MODE_START, 0, COORD_MAX, 0, COORD_MAX - 3, 1'b0);
    repeat (4) advance_request();
    send_request(MODE_START, COORD_MAX - 2, 5, COORD_MAX, 5, 1'b1);
    repeat (3) advance_request();
    send_request(MODE_START, 10, 10, 8, 15, 1'b0);
    repeat (2) advance_request();
    send_request(MODE_START, 0, 0, COORD_MAX, COORD_MAX, 1'b1);
    repeat (3) advance_request();
    send_request(MODE_START, COORD_MAX, COORD_MAX, 0, 0, 1'b0);
    repeat (2) advance_request();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_request(MODE_START, 300, 350, 420, 300, 1'b0);
    fork
      begin
        hold_off <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    while (line_active) advance_request();
  endtask

  function automatic int pick_end(int s, int d);
    int e;
    e = $urandom_range(1) ? s + d : s - d;
    if (e > COORD_MAX) e = s - d;
    if (e < 0) e = s + d;
    return e;
  endfunction

  task automatic test_random_lines(int idle_pct, int stall_pct, int budget);
    int stop_at, sx, sy, dx, dy;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = requests_sent + budget;
    while (requests_sent < stop_at) begin
      if ($urandom_range(99) < 10) begin
        send_request(mode_e'($urandom_range(1)), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                     $urandom_range(COORD_MAX), 1'($urandom_range(1)));
      end else begin
        sx = $urandom_range(COORD_MAX);
        sy = $urandom_range(COORD_MAX);
        dx = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(80);
        dy = ($urandom_range(99) < 85) ? $urandom_range(12) : $urandom_range(80);
        send_request(MODE_START, sx, sy, pick_end(sx, dx), pick_end(sy, dy),
                     1'($urandom_range(1)));
        while (line_active && $urandom_range(99) >= 3) advance_request();
        if ($urandom_range(99) < 10) advance_request();
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    req_if.valid   <= 1'b0;
    req_if.mode    <= MODE_START;
    req_if.start_x <= '0;
    req_if.start_y <= '0;
    req_if.end_x   <= '0;
    req_if.end_y   <= '0;
    req_if.restore <= 1'b0;
    hold_off       <= 1'b0;
    line_active     = 1'b0;
    walk_x          = '0;
    walk_y          = '0;
    goal_x          = '0;
    goal_y          = '0;
    dist_x          = 0;
    dist_y          = 0;
    down_x          = 1'b0;
    down_y          = 1'b0;
    slope_err       = 0;
    restore_latched = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    requests_sent   = 0;
    lines_started   = 0;
    pixels_checked  = 0;
    pixel_errors    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_lines();
    test_output_hold_off();
    test_random_lines(0, 0, 350);
    test_random_lines(68, 0, 350);
    test_random_lines(0, 68, 350);
    test_random_lines(9, 9, 350);

    req_if.valid <= 1'b0;
    while (pixel_expected.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (pixel_expected.size() > 0) begin
      pixel_errors++;
      $display("%0d expected pixels never arrived", pixel_expected.size());
    end
    $display("Sent %0d requests starting %0d lines; checked %0d pixels, %0d errors.",
             requests_sent, lines_started, pixels_checked, pixel_errors);
    $display("Covered corner lines, a long output hold-off and four idle/stall settings.");
    if (pixel_errors == 0) begin
      $display("PASS line_rasterizer");
    end else begin
      $display("FAIL line_rasterizer");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout waiting for the run to finish");
    $display("FAIL line_rasterizer");
    $finish;
  end

endmodule
